/* rtl/ltt_pkg.sv */
`default_nettype none
package ltt_pkg;

	localparam int unsigned DATA_W        = 16;
	localparam int unsigned AVG_DEPTH_DEF = 32;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned DIV_W         = 32;
	localparam int unsigned DIV_CNT_W     = $clog2(DIV_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESTRICT = 2'd0,
		CFG_SHUTDOWN = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_RESTRICT = 2'd1,
		MODE_SHUTDOWN = 2'd2
	} mode_t;

	localparam logic OP_COLOUR = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [DATA_W-1:0] START_RED   = 16'd0;
	localparam logic [DATA_W-1:0] START_GREEN = 16'd1;
	localparam logic [DATA_W-1:0] START_BLUE  = 16'd0;
	localparam logic [DATA_W-1:0] SHUT_RED    = 16'd1;
	localparam logic [DATA_W-1:0] SHUT_OTHER  = 16'd0;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

/* rtl/ltt_if.sv */
`default_nettype none
interface ltt_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] req_red;
	logic [15:0] req_green;
	logic [15:0] req_blue;
	logic [15:0] temp_sample;

	modport source (output valid, op, req_red, req_green, req_blue, temp_sample, input ready);
	modport sink (input valid, op, req_red, req_green, req_blue, temp_sample, output ready);
endinterface

interface ltt_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] drive_red;
	logic [15:0] drive_green;
	logic [15:0] drive_blue;
	logic [1:0]  thermal_mode;
	logic [15:0] avg_temp;

	modport source (output valid, drive_red, drive_green, drive_blue, thermal_mode, avg_temp,
		input ready);
	modport sink (input valid, drive_red, drive_green, drive_blue, thermal_mode, avg_temp,
		output ready);
endinterface
`default_nettype wire

/* rtl/ltt_ring.sv */
`default_nettype none
module ltt_ring #(
	parameter int unsigned AVG_DEPTH = ltt_pkg::AVG_DEPTH_DEF,
	localparam int unsigned AW = $clog2(AVG_DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output      logic [ltt_pkg::DATA_W-1:0]  rd_data,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [ltt_pkg::DATA_W-1:0]  wr_data
);

	logic [ltt_pkg::DATA_W-1:0] mem [AVG_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/ltt_div.sv */
`default_nettype none
module ltt_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ltt_pkg::div_req_t req,
	output      ltt_pkg::div_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [ltt_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [ltt_pkg::DATA_W-1:0]      rem_q;
	logic [ltt_pkg::DATA_W-1:0]      dvs_q;
	logic [ltt_pkg::DIV_W-1:0]       quo_q;
	logic [ltt_pkg::DATA_W:0]        shifted;
	logic                            fits;
	logic [ltt_pkg::DATA_W:0]        diff;

	assign shifted = {rem_q, quo_q[ltt_pkg::DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == ltt_pkg::DIV_CNT_W'(ltt_pkg::DIV_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ltt_pkg::DIV_CNT_W'(ltt_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ltt_pkg::DATA_W-1:0] : shifted[ltt_pkg::DATA_W-1:0];
			quo_q <= {quo_q[ltt_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[ltt_pkg::DATA_W-1:0];

endmodule
`default_nettype wire

/* rtl/led_thermal_throttle.sv */
`default_nettype none
// Request to result: a sample passes S_RD and S_AVG; then S_CMP runs once per component, then S_DONE.
// Each component scaled in restrict mode adds S_MUL (multiply) and S_DIV (32-step divide).
// One request at a time; the next is taken the cycle after a result is registered. The
// scaled components take turns on the single shared restoring divider.
// A finished result waits in the output register. Reset: arst_n clears thresholds, ring
// pointer, sum, average, mode and held colour (0,1,0).
module led_thermal_throttle #(
	parameter int unsigned AVG_DEPTH = ltt_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [ltt_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [ltt_pkg::DATA_W-1:0]    wr_data,
	ltt_req_if.sink                            req_ch,
	ltt_rsp_if.source                          rsp_ch
);

	localparam int unsigned AW        = $clog2(AVG_DEPTH);
	localparam int unsigned SUM_W     = ltt_pkg::DATA_W + AW;
	localparam int unsigned DW        = ltt_pkg::DATA_W;
	localparam int unsigned AVG_SHIFT = SUM_W + AW;
	// reciprocal of the ring depth, exact for any sum that fits SUM_W bits
	localparam logic [SUM_W:0] AVG_RECIP = (SUM_W+1)'(((64'd1 << AVG_SHIFT)
		+ 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_AVG  = 7'b0000100,
		S_CMP  = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [DW-1:0]          rs_q;
	logic [DW-1:0]          ss_q;
	logic [DW-1:0]          held_q [3];
	logic [DW-1:0]          drv_q [3];
	logic [1:0]             k_q;
	logic [DW-1:0]          sample_q;
	logic [DW-1:0]          first_q;
	logic [AW-1:0]          ptr_q;
	logic                   primed_q;
	logic                   wrapped_q;
	logic [SUM_W-1:0]       sum_q;
	logic [DW-1:0]          avg_q;
	ltt_pkg::mode_t         mode_q;
	logic [2*DW-1:0]        prod_q;
	logic                   out_valid_q;

	logic                   accept;
	logic [DW-1:0]          ring_rd;
	logic [DW-1:0]          old_s;
	logic [SUM_W-1:0]       sum_new;
	logic [2*SUM_W:0]       avg_prod;
	logic [DW-1:0]          avg_new;
	logic [DW-1:0]          comp;
	logic [DW-1:0]          span;
	logic [DW-1:0]          excess;
	ltt_pkg::div_req_t      div_req;
	ltt_pkg::div_rsp_t      div_rsp;

	assign req_ch.ready = (state_q == S_IDLE);
	assign accept       = req_ch.valid && req_ch.ready;

	ltt_ring #(.AVG_DEPTH(AVG_DEPTH)) u_ring (
		.clk     (clk),
		.rd_en   (accept && (req_ch.op == ltt_pkg::OP_SAMPLE)),
		.rd_addr (ptr_q),
		.rd_data (ring_rd),
		.wr_en   (state_q == S_RD),
		.wr_addr (ptr_q),
		.wr_data (sample_q)
	);

	ltt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign old_s    = wrapped_q ? ring_rd : first_q;
	assign sum_new  = primed_q ? (sum_q - SUM_W'(old_s) + SUM_W'(sample_q))
	                           : SUM_W'(SUM_W'(sample_q) * SUM_W'(AVG_DEPTH));
	assign avg_prod = (2*SUM_W+1)'(sum_q) * (2*SUM_W+1)'(AVG_RECIP);
	assign avg_new  = avg_prod[AVG_SHIFT +: DW];
	assign comp     = held_q[k_q];
	assign span     = ss_q - rs_q;
	assign excess   = avg_q - rs_q;

	always_comb begin
		div_req.start    = (state_q == S_MUL);
		div_req.dividend = prod_q;
		div_req.divisor  = span;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= '0;
			ss_q <= '0;
		end else if (wr_en) begin
			if (wr_index == ltt_pkg::CFG_RESTRICT) begin
				rs_q <= wr_data;
			end else if (wr_index == ltt_pkg::CFG_SHUTDOWN) begin
				ss_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			ptr_q       <= '0;
			primed_q    <= 1'b0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			avg_q       <= '0;
			mode_q      <= ltt_pkg::MODE_NORMAL;
			held_q[0]   <= ltt_pkg::START_RED;
			held_q[1]   <= ltt_pkg::START_GREEN;
			held_q[2]   <= ltt_pkg::START_BLUE;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (accept) begin
						if (req_ch.op == ltt_pkg::OP_SAMPLE) begin
							state_q <= S_RD;
						end else begin
							held_q[0] <= req_ch.req_red;
							held_q[1] <= req_ch.req_green;
							held_q[2] <= req_ch.req_blue;
							state_q   <= S_CMP;
						end
					end
				end
				S_RD: begin
					sum_q    <= sum_new;
					primed_q <= 1'b1;
					if (ptr_q == AW'(AVG_DEPTH - 1)) begin
						ptr_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
					state_q <= S_AVG;
				end
				S_AVG: begin
					avg_q <= avg_new;
					if (avg_new < rs_q) begin
						mode_q <= ltt_pkg::MODE_NORMAL;
					end else if (avg_new < ss_q) begin
						mode_q <= ltt_pkg::MODE_RESTRICT;
					end else begin
						mode_q <= ltt_pkg::MODE_SHUTDOWN;
					end
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (mode_q == ltt_pkg::MODE_RESTRICT && avg_q >= rs_q
							&& ss_q > rs_q && avg_q < ss_q) begin
						state_q <= S_MUL;
					end else if (k_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (k_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_CMP;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= req_ch.temp_sample;
		end
		if (state_q == S_RD && !primed_q) begin
			first_q <= sample_q;
		end
		if (state_q == S_CMP) begin
			prod_q <= {{DW{1'b0}}, comp} * {{DW{1'b0}}, excess};
			case (mode_q)
				ltt_pkg::MODE_NORMAL: begin
					drv_q[k_q] <= comp;
				end
				ltt_pkg::MODE_RESTRICT: begin
					if (avg_q < rs_q) begin
						drv_q[k_q] <= comp;
					end else begin
						drv_q[k_q] <= '0;
					end
				end
				default: begin
					drv_q[k_q] <= (k_q == 2'd0) ? ltt_pkg::SHUT_RED : ltt_pkg::SHUT_OTHER;
				end
			endcase
		end
		if (state_q == S_DIV && div_rsp.done) begin
			drv_q[k_q] <= comp - div_rsp.quotient;
		end
		if (state_q == S_DONE && (!out_valid_q || rsp_ch.ready)) begin
			rsp_ch.drive_red    <= drv_q[0];
			rsp_ch.drive_green  <= drv_q[1];
			rsp_ch.drive_blue   <= drv_q[2];
			rsp_ch.thermal_mode <= mode_q;
			rsp_ch.avg_temp     <= avg_q;
		end
	end

	assign rsp_ch.valid = out_valid_q;

endmodule
`default_nettype wire
